/* design/pcg32_pkg.sv */
// ----------------------------------------------------------------------------
// pcg32_pkg: shared types and constants for the PCG32 generator
// Request codes, LCG and splitmix64 constants, and the command/status
// structs that join the controller to the datapath.
// ----------------------------------------------------------------------------
package pcg32_pkg;

    localparam logic [63:0] LCG_MUL         = 64'h5851_F42D_4C95_7F2D;
    localparam logic [63:0] LCG_INC         = 64'h1405_7B7E_F767_814F;
    localparam logic [63:0] SM_GOLDEN       = 64'h9E37_79B9_7F4A_7C15;
    localparam logic [63:0] SM_MUL1         = 64'hBF58_476D_1CE4_E5B9;
    localparam logic [63:0] SM_MUL2         = 64'h94D0_49BB_1331_11EB;
    localparam logic [63:0] BASE_SEED_RESET = 64'h1234_5678_90AB_CDEF;

    // APB: one 64-bit register at byte address 8*i, index taken from paddr[3]
    localparam int unsigned PADDR_W           = 4;
    localparam logic        CFG_IDX_BASE_SEED = 1'b0;

    typedef enum logic [1:0] {
        REQ_RAW     = 2'd0,
        REQ_BOUNDED = 2'd1,
        REQ_FRAC    = 2'd2,
        REQ_RESEED  = 2'd3
    } req_t;

    typedef enum logic [2:0] {
        ACC_HOLD,
        ACC_SEED_NEW,
        ACC_SEED_BASE,
        ACC_XS30,
        ACC_XS27,
        ACC_XS31,
        ACC_LOAD_STATE
    } acc_op_t;

    typedef enum logic [1:0] {
        MC_LCG,
        MC_SM1,
        MC_SM2
    } mul_const_t;

    typedef enum logic [1:0] {
        ST_HOLD,
        ST_SEED,
        ST_STEP
    } st_op_t;

    typedef enum logic [1:0] {
        RES_ZERO,
        RES_DRAW,
        RES_FRAC,
        RES_REM
    } res_sel_t;

    typedef enum logic {
        MOD_THR,
        MOD_DRAW
    } mod_sel_t;

    typedef struct packed {
        logic       cap;
        acc_op_t    acc_op;
        logic       mul_en;
        logic [1:0] mul_phase;
        mul_const_t mul_const;
        st_op_t     st_op;
        logic       draw_cap;
        logic       mod_start;
        mod_sel_t   mod_sel;
        logic       thr_cap;
        logic       load_out;
        res_sel_t   res_sel;
    } cmd_t;

    typedef struct packed {
        logic state_zero;
        logic bound_small;
        logic draw_ge_thr;
        logic mod_done;
    } stat_t;

endpackage

/* design/pcg32_random_generator.sv */
// ----------------------------------------------------------------------------
// pcg32_random_generator: PCG32 (XSH-RR) random number generator
// Raw, bounded, unit-fraction and reseed requests on a valid/stall channel,
// base seed register on an APB port.
// ----------------------------------------------------------------------------
// Sequencing: a raw/fraction draw seeds the state first when it is still zero;
//   a reseed runs the splitmix64 seeding alone and returns 0.
// Bounded draw: threshold modulo, then draws until one is not rejected, then
//   the final modulo; bound 0 or 1 returns 0 without drawing.
// Throughput: one transaction at a time; the multiply and modulo are iterative.
// Reset: state cleared to zero (unseeded), base_seed to 0x1234567890ABCDEF.
// ----------------------------------------------------------------------------
module pcg32_random_generator (
    input  logic                            clk,
    input  logic                            rst_n,

    // request channel
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [1:0]                      req_type,
    input  logic [63:0]                     new_seed,
    input  logic [31:0]                     bound,

    // result channel
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [31:0]                     value,

    // APB configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [pcg32_pkg::PADDR_W-1:0]   paddr,
    input  logic [63:0]                     pwdata,
    output logic [63:0]                     prdata,
    output logic                            pready
);

    pcg32_pkg::cmd_t  cmd;
    pcg32_pkg::stat_t stat;
    logic             cfg_write;
    logic             cfg_sel_seed;
    logic [63:0]      base_seed;

    // Single register: base_seed at byte address 0; anything else reads 0
    // and ignores writes. Writes only store the seed, the state is untouched.
    assign pready       = 1'b1;
    assign cfg_sel_seed = (paddr[pcg32_pkg::PADDR_W-1] == pcg32_pkg::CFG_IDX_BASE_SEED);
    assign cfg_write    = psel && penable && pwrite && pready && cfg_sel_seed;
    assign prdata       = cfg_sel_seed ? base_seed : 64'd0;

    // Controller: sequences one transaction at a time. The result sits in an
    // output register, so the next request is accepted while it waits.
    pcg32_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .req_type  (req_type),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Datapath: generator state, splitmix64 seeding, LCG step, XSH-RR
    // permutation, rejection threshold and modulo by the bound.
    pcg32_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .new_seed  (new_seed),
        .bound     (bound),
        .cfg_we    (cfg_write),
        .cfg_wdata (pwdata),
        .base_seed (base_seed),
        .value     (value)
    );

endmodule

/* design/pcg32_mod.sv */
// ----------------------------------------------------------------------------
// pcg32_mod: iterative 32-bit modulo unit
// Restoring shift/subtract, one dividend bit per cycle; done pulses for one
// cycle once the last bit is processed, with the remainder valid.
// ----------------------------------------------------------------------------
module pcg32_mod (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [31:0] rem
);

    logic        active_reg;
    logic        done_reg;
    logic [4:0]  cnt_reg;
    logic [31:0] dvd_reg;
    logic [31:0] rem_reg;

    logic [32:0] trial;
    logic [33:0] diff;
    logic [31:0] rem_next;

    always_comb
    begin
        trial    = {rem_reg, dvd_reg[31]};
        diff     = {1'b0, trial} - {2'b00, divisor};
        rem_next = diff[33] ? trial[31:0] : diff[31:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
            cnt_reg    <= '0;
        end
        else if (start)
        begin
            active_reg <= 1'b1;
            done_reg   <= 1'b0;
            cnt_reg    <= '1;
        end
        else if (active_reg)
        begin
            cnt_reg <= cnt_reg - 5'd1;
            if (cnt_reg == 5'd0)
            begin
                active_reg <= 1'b0;
                done_reg   <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            rem_reg <= '0;
        end
        else if (active_reg)
        begin
            dvd_reg <= {dvd_reg[30:0], 1'b0};
            rem_reg <= rem_next;
        end
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

/* design/pcg32_dp.sv */
// ----------------------------------------------------------------------------
// pcg32_dp: generator datapath
// State and work registers, a shared 32x32 multiplier stepped over four
// phases for 64-bit products, XSH-RR output permutation, modulo unit.
// ----------------------------------------------------------------------------
module pcg32_dp (
    input  logic                clk,
    input  logic                rst_n,
    input  pcg32_pkg::cmd_t     cmd,
    output pcg32_pkg::stat_t    stat,
    input  logic [63:0]         new_seed,
    input  logic [31:0]         bound,
    input  logic                cfg_we,
    input  logic [63:0]         cfg_wdata,
    output logic [63:0]         base_seed,
    output logic [31:0]         value
);

    logic [63:0] base_seed_reg;
    logic [63:0] rng_state_reg;
    logic [63:0] seed_in_reg;
    logic [31:0] bound_reg;
    logic [63:0] acc_reg;
    logic [63:0] macc_reg;
    logic [63:0] prod_reg;
    logic [31:0] draw_reg;
    logic [31:0] thr_reg;
    logic [31:0] value_reg;

    logic [63:0] mul_const;
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] prod_next;
    logic [31:0] perm;
    logic [31:0] mod_dividend;
    logic [31:0] mod_rem;
    logic        mod_done;

    // XSH-RR: xorshift the old state, then rotate right by its top five bits
    function automatic logic [31:0] xsh_rr(input logic [63:0] old);
        logic [63:0] mix;
        logic [31:0] xs;
        logic [63:0] dbl;
        mix = old ^ (old >> 18);
        xs  = mix[58:27];
        dbl = {xs, xs} >> old[63:59];
        return dbl[31:0];
    endfunction

    always_comb
    begin
        unique case (cmd.mul_const)
            pcg32_pkg::MC_SM1: mul_const = pcg32_pkg::SM_MUL1;
            pcg32_pkg::MC_SM2: mul_const = pcg32_pkg::SM_MUL2;
            default:           mul_const = pcg32_pkg::LCG_MUL;
        endcase
        // phase 0: lo*lo, phase 1: lo*hi, phase 2: hi*lo
        mul_a     = (cmd.mul_phase == 2'd2) ? acc_reg[63:32] : acc_reg[31:0];
        mul_b     = (cmd.mul_phase == 2'd1) ? mul_const[63:32] : mul_const[31:0];
        prod_next = mul_a * mul_b;
        perm      = xsh_rr(rng_state_reg);
        mod_dividend = (cmd.mod_sel == pcg32_pkg::MOD_THR) ? (32'd0 - bound_reg) : draw_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_seed_reg <= pcg32_pkg::BASE_SEED_RESET;
            rng_state_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                base_seed_reg <= cfg_wdata;
            end
            unique case (cmd.st_op)
                pcg32_pkg::ST_SEED: rng_state_reg <= (acc_reg == 64'd0) ? 64'd1 : acc_reg;
                pcg32_pkg::ST_STEP: rng_state_reg <= acc_reg + pcg32_pkg::LCG_INC;
                default:            rng_state_reg <= rng_state_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.cap)
        begin
            seed_in_reg <= new_seed;
            bound_reg   <= bound;
        end

        if (cmd.mul_en)
        begin
            prod_reg <= prod_next;
            if (cmd.mul_phase == 2'd1)
            begin
                macc_reg <= prod_reg;
            end
            else if (cmd.mul_phase == 2'd2)
            begin
                macc_reg[63:32] <= macc_reg[63:32] + prod_reg[31:0];
            end
        end

        if (cmd.mul_en && (cmd.mul_phase == 2'd3))
        begin
            acc_reg <= {macc_reg[63:32] + prod_reg[31:0], macc_reg[31:0]};
        end
        else
        begin
            unique case (cmd.acc_op)
                pcg32_pkg::ACC_SEED_NEW:   acc_reg <= seed_in_reg + pcg32_pkg::SM_GOLDEN;
                pcg32_pkg::ACC_SEED_BASE:  acc_reg <= base_seed_reg + pcg32_pkg::SM_GOLDEN;
                pcg32_pkg::ACC_XS30:       acc_reg <= acc_reg ^ (acc_reg >> 30);
                pcg32_pkg::ACC_XS27:       acc_reg <= acc_reg ^ (acc_reg >> 27);
                pcg32_pkg::ACC_XS31:       acc_reg <= acc_reg ^ (acc_reg >> 31);
                pcg32_pkg::ACC_LOAD_STATE: acc_reg <= rng_state_reg;
                default:                   acc_reg <= acc_reg;
            endcase
        end

        if (cmd.draw_cap)
        begin
            draw_reg <= perm;
        end
        if (cmd.thr_cap)
        begin
            thr_reg <= mod_rem;
        end

        if (cmd.load_out)
        begin
            unique case (cmd.res_sel)
                pcg32_pkg::RES_DRAW: value_reg <= draw_reg;
                pcg32_pkg::RES_FRAC: value_reg <= {8'd0, draw_reg[31:8]};
                pcg32_pkg::RES_REM:  value_reg <= mod_rem;
                default:             value_reg <= 32'd0;
            endcase
        end
    end

    pcg32_mod u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.mod_start),
        .dividend (mod_dividend),
        .divisor  (bound_reg),
        .done     (mod_done),
        .rem      (mod_rem)
    );

    always_comb
    begin
        stat.state_zero  = (rng_state_reg == 64'd0);
        stat.bound_small = (bound_reg[31:1] == 31'd0);
        stat.draw_ge_thr = (draw_reg >= thr_reg);
        stat.mod_done    = mod_done;
    end

    assign base_seed = base_seed_reg;
    assign value     = value_reg;

endmodule

/* design/pcg32_ctrl.sv */
// ----------------------------------------------------------------------------
// pcg32_ctrl: request sequencer
// Walks each transaction through seeding, draw, rejection and modulo steps
// and owns the input and output handshakes.
// ----------------------------------------------------------------------------
module pcg32_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [1:0]          req_type,
    output logic                out_valid,
    input  logic                out_stall,
    input  pcg32_pkg::stat_t    stat,
    output pcg32_pkg::cmd_t     cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_THR_WAIT,
        S_DRAW_CHK,
        S_SEED_ADD,
        S_SEED_X30,
        S_SEED_M1,
        S_SEED_X27,
        S_SEED_M2,
        S_SEED_X31,
        S_SEED_ST,
        S_DRAW,
        S_DRAW_MUL,
        S_DRAW_ADD,
        S_MOD_WAIT,
        S_FIN
    } state_t;

    state_t                state_reg, state_next;
    pcg32_pkg::req_t       req_reg, req_next;
    logic [1:0]            mcnt_reg, mcnt_next;
    pcg32_pkg::res_sel_t   res_sel_reg, res_sel_next;
    logic                  out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        req_next       = req_reg;
        mcnt_next      = 2'd0;
        res_sel_next   = res_sel_reg;
        out_valid_next = out_valid_reg && out_stall;

        cmd            = '0;
        cmd.acc_op     = pcg32_pkg::ACC_HOLD;
        cmd.mul_const  = pcg32_pkg::MC_LCG;
        cmd.st_op      = pcg32_pkg::ST_HOLD;
        cmd.mod_sel    = pcg32_pkg::MOD_THR;
        cmd.res_sel    = res_sel_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.cap    = 1'b1;
                    req_next   = pcg32_pkg::req_t'(req_type);
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                unique case (req_reg)
                    pcg32_pkg::REQ_RESEED: state_next = S_SEED_ADD;
                    pcg32_pkg::REQ_BOUNDED:
                    begin
                        if (stat.bound_small)
                        begin
                            res_sel_next = pcg32_pkg::RES_ZERO;
                            state_next   = S_FIN;
                        end
                        else
                        begin
                            cmd.mod_start = 1'b1;
                            cmd.mod_sel   = pcg32_pkg::MOD_THR;
                            state_next    = S_THR_WAIT;
                        end
                    end
                    default: state_next = S_DRAW_CHK;
                endcase
            end
            S_THR_WAIT:
            begin
                if (stat.mod_done)
                begin
                    cmd.thr_cap = 1'b1;
                    state_next  = S_DRAW_CHK;
                end
            end
            S_DRAW_CHK:
            begin
                state_next = stat.state_zero ? S_SEED_ADD : S_DRAW;
            end
            S_SEED_ADD:
            begin
                cmd.acc_op = (req_reg == pcg32_pkg::REQ_RESEED) ? pcg32_pkg::ACC_SEED_NEW
                                                                : pcg32_pkg::ACC_SEED_BASE;
                state_next = S_SEED_X30;
            end
            S_SEED_X30:
            begin
                cmd.acc_op = pcg32_pkg::ACC_XS30;
                state_next = S_SEED_M1;
            end
            S_SEED_M1:
            begin
                cmd.mul_en    = 1'b1;
                cmd.mul_phase = mcnt_reg;
                cmd.mul_const = pcg32_pkg::MC_SM1;
                mcnt_next     = mcnt_reg + 2'd1;
                if (mcnt_reg == 2'd3)
                begin
                    state_next = S_SEED_X27;
                end
            end
            S_SEED_X27:
            begin
                cmd.acc_op = pcg32_pkg::ACC_XS27;
                state_next = S_SEED_M2;
            end
            S_SEED_M2:
            begin
                cmd.mul_en    = 1'b1;
                cmd.mul_phase = mcnt_reg;
                cmd.mul_const = pcg32_pkg::MC_SM2;
                mcnt_next     = mcnt_reg + 2'd1;
                if (mcnt_reg == 2'd3)
                begin
                    state_next = S_SEED_X31;
                end
            end
            S_SEED_X31:
            begin
                cmd.acc_op = pcg32_pkg::ACC_XS31;
                state_next = S_SEED_ST;
            end
            S_SEED_ST:
            begin
                cmd.st_op = pcg32_pkg::ST_SEED;
                if (req_reg == pcg32_pkg::REQ_RESEED)
                begin
                    res_sel_next = pcg32_pkg::RES_ZERO;
                    state_next   = S_FIN;
                end
                else
                begin
                    state_next = S_DRAW;
                end
            end
            S_DRAW:
            begin
                cmd.draw_cap = 1'b1;
                cmd.acc_op   = pcg32_pkg::ACC_LOAD_STATE;
                state_next   = S_DRAW_MUL;
            end
            S_DRAW_MUL:
            begin
                cmd.mul_en    = 1'b1;
                cmd.mul_phase = mcnt_reg;
                cmd.mul_const = pcg32_pkg::MC_LCG;
                mcnt_next     = mcnt_reg + 2'd1;
                if (mcnt_reg == 2'd3)
                begin
                    state_next = S_DRAW_ADD;
                end
            end
            S_DRAW_ADD:
            begin
                cmd.st_op = pcg32_pkg::ST_STEP;
                unique case (req_reg)
                    pcg32_pkg::REQ_BOUNDED:
                    begin
                        if (stat.draw_ge_thr)
                        begin
                            cmd.mod_start = 1'b1;
                            cmd.mod_sel   = pcg32_pkg::MOD_DRAW;
                            state_next    = S_MOD_WAIT;
                        end
                        else
                        begin
                            state_next = S_DRAW_CHK;
                        end
                    end
                    pcg32_pkg::REQ_FRAC:
                    begin
                        res_sel_next = pcg32_pkg::RES_FRAC;
                        state_next   = S_FIN;
                    end
                    default:
                    begin
                        res_sel_next = pcg32_pkg::RES_DRAW;
                        state_next   = S_FIN;
                    end
                endcase
            end
            S_MOD_WAIT:
            begin
                if (stat.mod_done)
                begin
                    res_sel_next = pcg32_pkg::RES_REM;
                    state_next   = S_FIN;
                end
            end
            S_FIN:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            req_reg       <= pcg32_pkg::REQ_RAW;
            mcnt_reg      <= 2'd0;
            res_sel_reg   <= pcg32_pkg::RES_ZERO;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            req_reg       <= req_next;
            mcnt_reg      <= mcnt_next;
            res_sel_reg   <= res_sel_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

endmodule
